/* hdl/smsort_pkg.sv */
// Shared types and constants for the stable merge sorter.
`default_nettype none
package smsort_pkg;

  localparam int unsigned DATA_W       = 64;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MSETUP,
    S_MRUN,
    S_ESTART,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* hdl/smsort_in_if.sv */
// Input channel of the sorter: one element request per handshake.
`default_nettype none
interface smsort_in_if;
  logic                valid;
  logic                ready;
  smsort_pkg::elem_t   value;
  logic                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

/* hdl/smsort_out_if.sv */
// Output channel of the sorter: one sorted element per handshake.
`default_nettype none
interface smsort_out_if;
  logic                valid;
  logic                ready;
  smsort_pkg::elem_t   sorted_value;
  logic                final_res;
  logic                overflowed;

  modport source (output valid, output sorted_value, output final_res, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflowed,
                  output ready);
endinterface
`default_nettype wire

/* hdl/stable_merge_sorter.sv */
// Top level of the stable merge sorter: load, bottom-up merge passes, emit.
//
//   channel  dir  payload                                   handshake
//   din      in   value[63:0] signed, last                  valid/ready
//   dout     out  sorted_value[63:0] signed, final_res,     valid/ready
//                 overflowed
//
// Loading accepts one element per cycle; din is ready only while loading.
// Sorting of n elements runs ceil(log2 n) passes between two memories; each
// run (a lone tail run included) has a setup state, then writes one element
// per cycle in the merge state.
// One element is emitted per cycle with dout ready; a stalled dout holds it.
// Synchronous reset returns to loading with an empty store; no clearing pass.
`default_nettype none
module stable_merge_sorter #(
  parameter int unsigned CAPACITY = smsort_pkg::CAPACITY_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  smsort_in_if.sink    din,
  smsort_out_if.source dout
);
  import smsort_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = CW + 2;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic          drop;
  logic [LW-1:0] wid, lo, mid, hi, i, j, k;
  logic          src_b;
  logic [CW-1:0] eaddr;
  logic          ov;
  elem_t         od;
  logic          ofin;
  logic          oovf;

  // Memory ports
  logic          we_a, we_b;
  logic [AW-1:0] waddr_a, waddr_b;
  elem_t         wdata_a, wdata_b;
  logic [AW-1:0] raddr_l, raddr_r;
  elem_t         ra_l, ra_r, rb_l, rb_r;
  elem_t         rd_l, rd_r, merged;

  // Helpers
  logic          accept, full, load_out, take_left, merge_end, more_runs, more_pass;
  logic          emit_last;
  logic [CW-1:0] count_after;
  logic [LW-1:0] count_ext, mid_calc, hi_full, hi_calc, wid2, i_next, j_next;

  smsort_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram_a (
    .clk     (clk),
    .we      (we_a),
    .waddr   (waddr_a),
    .wdata   (wdata_a),
    .raddr_a (raddr_l),
    .raddr_b (raddr_r),
    .rdata_a (ra_l),
    .rdata_b (ra_r)
  );

  smsort_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram_b (
    .clk     (clk),
    .we      (we_b),
    .waddr   (waddr_b),
    .wdata   (wdata_b),
    .raddr_a (raddr_l),
    .raddr_b (raddr_r),
    .rdata_a (rb_l),
    .rdata_b (rb_r)
  );

  always_comb begin
    accept      = din.valid && (state == S_LOAD);
    full        = (count == CW'(CAPACITY));
    count_after = full ? count : count + CW'(1);
    count_ext   = LW'(count);
    rd_l        = src_b ? rb_l : ra_l;
    rd_r        = src_b ? rb_r : ra_r;
    wid2        = wid << 1;
    // a lone tail run has an empty right half and is copied across
    mid_calc    = ((lo + wid) > count_ext) ? count_ext : lo + wid;
    hi_full     = lo + wid2;
    hi_calc     = (hi_full > count_ext) ? count_ext : hi_full;
    // ties go to the left run
    take_left   = (i < mid) && ((j >= hi) || (rd_l <= rd_r));
    merged      = take_left ? rd_l : rd_r;
    i_next      = i + LW'(take_left);
    j_next      = j + LW'(!take_left);
    merge_end   = ((k + LW'(1)) == hi);
    more_runs   = (hi_full < count_ext);
    more_pass   = (wid2 < count_ext);
    load_out    = !ov || dout.ready;
    emit_last   = ((eaddr + CW'(1)) == count);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (accept && din.last) begin
          state_next = (count_after > CW'(1)) ? S_MSETUP : S_ESTART;
        end
      end
      S_MSETUP: state_next = S_MRUN;
      S_MRUN: begin
        if (merge_end) begin
          if (more_runs || more_pass) begin
            state_next = S_MSETUP;
          end else begin
            state_next = S_ESTART;
          end
        end
      end
      S_ESTART: state_next = S_EMIT;
      S_EMIT: begin
        if (load_out && emit_last) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Memory and handshake controls
  always_comb begin
    din.ready = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    waddr_a   = k[AW-1:0];
    waddr_b   = k[AW-1:0];
    wdata_a   = merged;
    wdata_b   = merged;
    raddr_l   = '0;
    raddr_r   = '0;
    case (state)
      S_LOAD: begin
        din.ready = 1'b1;
        we_a      = accept && !full;
        waddr_a   = count[AW-1:0];
        wdata_a   = din.value;
      end
      S_MSETUP: begin
        raddr_l = lo[AW-1:0];
        raddr_r = mid_calc[AW-1:0];
      end
      S_MRUN: begin
        // write into the other memory; aim the reads at the next heads
        we_a    = src_b;
        we_b    = !src_b;
        raddr_l = i_next[AW-1:0];
        raddr_r = j_next[AW-1:0];
      end
      S_ESTART: raddr_l = '0;
      S_EMIT: begin
        raddr_l = load_out ? eaddr[AW-1:0] + AW'(1) : eaddr[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      drop  <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && load_out) begin
        ov <= 1'b1;
      end else if (dout.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= count_after;
            if (full) begin
              drop <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (load_out && emit_last) begin
            count <= '0;
            drop  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Merge and emit bookkeeping
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        wid   <= LW'(1);
        lo    <= '0;
        src_b <= 1'b0;
      end
      S_MSETUP: begin
        mid <= mid_calc;
        hi  <= hi_calc;
        i   <= lo;
        j   <= mid_calc;
        k   <= lo;
      end
      S_MRUN: begin
        i <= i_next;
        j <= j_next;
        k <= k + LW'(1);
        if (merge_end) begin
          if (more_runs) begin
            lo <= hi_full;
          end else begin
            // pass done: the freshly written memory becomes the source
            lo    <= '0;
            wid   <= wid2;
            src_b <= !src_b;
          end
        end
      end
      S_ESTART: eaddr <= '0;
      S_EMIT: begin
        if (load_out) begin
          eaddr <= eaddr + CW'(1);
          od    <= rd_l;
          ofin  <= emit_last;
          oovf  <= drop;
        end
      end
      default: ;
    endcase
  end

  assign dout.valid        = ov;
  assign dout.sorted_value = od;
  assign dout.final_res    = ofin;
  assign dout.overflowed   = oovf;

  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MRUN) |-> (i <= mid && j <= hi && k < hi))
    else $error("merge indices out of run bounds");

  a_merge_conserve: assert property (@(posedge clk) disable iff (rst)
    (state == S_MRUN) |-> ((k + mid) == (i + j)))
    else $error("merge output count differs from consumed elements");

  a_width_pow2: assert property (@(posedge clk) disable iff (rst)
    (state == S_MSETUP) |-> $onehot(wid))
    else $error("run width is not a power of two");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (eaddr < count))
    else $error("emit pointer past stored elements");

endmodule
`default_nettype wire

/* hdl/smsort_ram.sv */
// Element memory: one write port, two read ports with registered read data.
`default_nettype none
module smsort_ram #(
  parameter int unsigned DEPTH = smsort_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(smsort_pkg::CAPACITY_DEF)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire smsort_pkg::elem_t wdata,
  input  wire logic [AW-1:0]     raddr_a,
  input  wire logic [AW-1:0]     raddr_b,
  output smsort_pkg::elem_t      rdata_a,
  output smsort_pkg::elem_t      rdata_b
);
  import smsort_pkg::*;

  elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire
